// File: src/sparse_matrix_transposer_macros.svh
// Assertion macros for the sparse matrix transposer.
`ifndef SPARSE_MATRIX_TRANSPOSER_MACROS_SVH
`define SPARSE_MATRIX_TRANSPOSER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SMT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SMT_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) cond |=> prop) else $error(msg);
`else
`define SMT_ASSERT(label, prop, msg)
`define SMT_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

// File: src/smt_pkg.sv
`timescale 1ns / 1ps
package smt_pkg;
	localparam int MaxColumns  = 256;
	localparam int MaxRows     = 1024;
	localparam int MaxNonzeros = 1024;
	localparam int ValueBits   = 64;
	localparam int ColW  = $clog2(MaxColumns);
	localparam int RowW  = $clog2(MaxRows);
	localparam int IdxW  = $clog2(MaxNonzeros);
	localparam int CntW  = IdxW + 1;
	localparam int PtrAW = $clog2(MaxColumns + 1);
	localparam int EntW  = RowW + ColW + ValueBits;
	localparam int OutW  = RowW + ValueBits;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_FINISH = 2'd1;
	localparam logic [1:0] CMD_RDPTR  = 2'd2;
	localparam logic [1:0] CMD_RDENT  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOT_DONE = 2'd3;

	localparam logic [1:0] REG_COLS = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_CNT_RD, S_CNT_WAIT, S_CNT_UPD, S_SCAN_RD, S_SCAN_WAIT,
		S_SCAT_RD, S_SCAT_WAIT, S_SCAT_PTR, S_SCAT_WR, S_READ_WAIT, S_OUT
	} state_t;
endpackage

// File: src/smt_ram.sv
`timescale 1ns / 1ps
module smt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// File: src/sparse_matrix_transposer.sv
`timescale 1ns / 1ps
// Results: a load result is valid in the cycle after acceptance, a read result after S_READ_WAIT.
// Flow: one word at a time; the block stalls its input while busy, until the result
//   is taken.
// Finish: the control walks the count memory once for clearing, once for the prefix
//   sum, and the entry buffer twice.
// Reset: arst_n clears control state, count, finished flag and registers
//   (column_count 256, row_count 1024); memories are not cleared.
`include "sparse_matrix_transposer_macros.svh"
module sparse_matrix_transposer import smt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           cmd,
	input  logic [RowW-1:0]      row,
	input  logic [ColW-1:0]      col,
	input  logic [ValueBits-1:0] value,
	input  logic [CntW-1:0]      position,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [CntW-1:0]      pointer,
	output logic [RowW-1:0]      out_row,
	output logic [ValueBits-1:0] out_value,
	output logic [CntW-1:0]      entry_count
);
	// configuration registers
	logic [8:0]  column_count_q;
	logic [10:0] row_count_q;
	logic        wr_en;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= 9'd256;
			row_count_q    <= 11'd1024;
		end else if (wr_en) begin
			if (paddr[2] == REG_COLS[0]) column_count_q <= pwdata[8:0];
			else row_count_q <= pwdata[10:0];
		end
	end
	always_comb begin
		if (paddr[2] == REG_ROWS[0]) prdata = {21'd0, row_count_q};
		else prdata = {23'd0, column_count_q};
	end

	// effective limits, saturated to the build maxima
	logic [CntW-1:0] eff_cols, eff_rows;
	assign eff_cols = (column_count_q > 9'(MaxColumns)) ? CntW'(MaxColumns)
		: CntW'(column_count_q);
	assign eff_rows = (row_count_q > 11'(MaxRows)) ? CntW'(MaxRows) : CntW'(row_count_q);

	// state
	state_t state_q, state_d;
	logic [CntW-1:0] loaded_q;
	logic            finished_q;
	logic [PtrAW:0]  ci_q;       // column walk index, wide to hold end
	logic [CntW-1:0] ei_q;       // entry walk index
	logic [CntW-1:0] acc_q;      // running prefix sum
	logic [1:0]      cmd_q;
	logic [CntW-1:0] pos_q;
	logic [1:0]      status_q;
	logic [CntW-1:0] ptr_q;
	logic            ptr_rd_q;

	// memories
	logic            buf_we;
	logic [IdxW-1:0] buf_wa, buf_ra;
	logic [EntW-1:0] buf_rd;
	logic            cnt_we;       // counts, then prefix pointers
	logic [PtrAW-1:0] cnt_wa, cnt_ra;
	logic [CntW-1:0] cnt_wd, cnt_rd;
	logic            slot_we;
	logic [ColW-1:0] slot_wa, slot_ra;
	logic [CntW-1:0] slot_wd, slot_rd;
	logic            out_we;
	logic [IdxW-1:0] out_wa, out_ra;
	logic [OutW-1:0] out_rd;
	logic [EntW-1:0] ent_q;

	smt_ram #(.Width(EntW), .Depth(MaxNonzeros)) u_buf (.clk, .we(buf_we),
		.waddr(buf_wa), .wdata({row, col, value}), .raddr(buf_ra), .rdata(buf_rd));
	smt_ram #(.Width(CntW), .Depth(1 << PtrAW)) u_ptr (.clk, .we(cnt_we),
		.waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd));
	smt_ram #(.Width(CntW), .Depth(MaxColumns)) u_slot (.clk, .we(slot_we),
		.waddr(slot_wa), .wdata(slot_wd), .raddr(slot_ra), .rdata(slot_rd));
	smt_ram #(.Width(OutW), .Depth(MaxNonzeros)) u_out (.clk, .we(out_we),
		.waddr(out_wa), .wdata({ent_q[EntW-1 -: RowW], ent_q[ValueBits-1:0]}),
		.raddr(out_ra), .rdata(out_rd));

	logic acc_in;
	logic ld_range, ld_full;
	assign acc_in   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign ld_range = (CntW'(col) >= eff_cols) || (CntW'(row) >= eff_rows);
	assign ld_full  = finished_q ? 1'b0 : (loaded_q == CntW'(MaxNonzeros));

	logic [ColW-1:0] ent_col;
	assign ent_col = ent_q[ValueBits +: ColW];
	logic [ColW-1:0] rd_col;       // column of the word on the buffer read port
	assign rd_col = buf_rd[ValueBits +: ColW];
	logic ci_end;
	assign ci_end = (ci_q == (PtrAW+1)'(MaxColumns + 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc_in) begin
					case (cmd)
						CMD_FINISH: state_d = S_CLR;
						CMD_RDPTR, CMD_RDENT: state_d = S_READ_WAIT;
						default: state_d = S_OUT;
					endcase
				end
			end
			S_CLR:      state_d = ci_end ? S_CNT_RD : S_CLR;
			S_CNT_RD:   state_d = (ei_q == loaded_q) ? S_SCAN_RD : S_CNT_WAIT;
			S_CNT_WAIT: state_d = S_CNT_UPD;
			S_CNT_UPD:  state_d = S_CNT_RD;
			S_SCAN_RD:  state_d = ci_end ? S_SCAT_RD : S_SCAN_WAIT;
			S_SCAN_WAIT: state_d = S_SCAN_RD;
			S_SCAT_RD:  state_d = (ei_q == loaded_q) ? S_OUT : S_SCAT_WAIT;
			S_SCAT_WAIT: state_d = S_SCAT_PTR;
			S_SCAT_PTR: state_d = S_SCAT_WR;
			S_SCAT_WR:  state_d = S_SCAT_RD;
			S_READ_WAIT: state_d = S_OUT;
			S_OUT:      state_d = out_stall ? S_OUT : S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		buf_we = 1'b0; buf_wa = loaded_q[IdxW-1:0] & {IdxW{~finished_q}};
		buf_ra = ei_q[IdxW-1:0];
		cnt_we = 1'b0; cnt_wa = ci_q[PtrAW-1:0]; cnt_wd = '0;
		cnt_ra = PtrAW'(pos_q);       // count and output read ports hold the request position
		slot_we = 1'b0; slot_wa = ci_q[ColW-1:0]; slot_wd = acc_q;
		slot_ra = ent_col;
		out_we = 1'b0; out_wa = slot_rd[IdxW-1:0]; out_ra = pos_q[IdxW-1:0];
		case (state_q)
			S_IDLE: begin
				buf_we = acc_in && (cmd == CMD_LOAD) && !ld_range && !ld_full;
			end
			S_CLR: cnt_we = !ci_end;
			S_CNT_WAIT: cnt_ra = PtrAW'(rd_col) + PtrAW'(1);
			S_CNT_UPD: begin
				cnt_we = 1'b1;
				cnt_wa = PtrAW'(ent_col) + PtrAW'(1);
				cnt_wd = cnt_rd + CntW'(1);
			end
			S_SCAN_RD: cnt_ra = ci_q[PtrAW-1:0];
			S_SCAN_WAIT: begin
				cnt_we = 1'b1;
				cnt_wd = acc_q + cnt_rd;
				slot_we = (ci_q < (PtrAW+1)'(MaxColumns));
				slot_wd = acc_q + cnt_rd;
			end
			S_SCAT_WAIT: slot_ra = rd_col;
			S_SCAT_PTR: begin
				slot_we = 1'b1;
				slot_wa = ent_col;
				slot_wd = slot_rd + CntW'(1);
			end
			S_SCAT_WR: begin
				out_we = 1'b1;
				out_wa = ptr_q[IdxW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			loaded_q <= '0;
			finished_q <= 1'b0;
			ci_q <= '0;
			ei_q <= '0;
			acc_q <= '0;
			status_q <= ST_OK;
			ptr_rd_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: if (acc_in) begin
					ptr_rd_q <= 1'b0;
					ci_q <= '0; ei_q <= '0; acc_q <= '0;
					case (cmd)
						CMD_LOAD: begin
							finished_q <= 1'b0;
							if (ld_range) status_q <= ST_RANGE;
							else if (ld_full) status_q <= ST_FULL;
							else begin
								status_q <= ST_OK;
								loaded_q <= (finished_q ? '0 : loaded_q) + CntW'(1);
							end
							if (finished_q && ld_range) loaded_q <= '0;
						end
						CMD_FINISH: status_q <= ST_OK;
						CMD_RDPTR: begin
							if (!finished_q) status_q <= ST_NOT_DONE;
							else if (position > eff_cols) status_q <= ST_RANGE;
							else begin status_q <= ST_OK; ptr_rd_q <= 1'b1; end
						end
						default: begin
							if (!finished_q) status_q <= ST_NOT_DONE;
							else if (position >= loaded_q) status_q <= ST_RANGE;
							else status_q <= ST_OK;
						end
					endcase
				end
				S_CLR: if (ci_end) ci_q <= '0; else ci_q <= ci_q + 1'b1;
				S_CNT_UPD: ei_q <= ei_q + 1'b1;
				S_SCAN_WAIT: begin
					acc_q <= acc_q + cnt_rd;
					ci_q <= ci_q + 1'b1;
				end
				S_SCAN_RD: if (ci_end) ei_q <= '0;
				S_SCAT_PTR: ptr_q <= slot_rd;
				S_SCAT_WR: ei_q <= ei_q + 1'b1;
				S_SCAT_RD: if (ei_q == loaded_q) finished_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// entry register fed by the buffer read port; request command and position registers
	always_ff @(posedge clk) begin
		if (state_q == S_CNT_WAIT || state_q == S_SCAT_WAIT) ent_q <= buf_rd;
		cmd_q <= (state_q == S_IDLE && acc_in) ? cmd : cmd_q;
		pos_q <= (state_q == S_IDLE && acc_in) ? position : pos_q;
	end

	// outputs
	assign out_valid   = (state_q == S_OUT);
	assign entry_count = loaded_q;
	assign pointer     = (state_q == S_OUT && ptr_rd_q && cmd_q == CMD_RDPTR) ? cnt_rd : '0;
	assign status      = status_q;
	logic ent_ok;
	assign ent_ok    = (cmd_q == CMD_RDENT) && (status_q == ST_OK);
	assign out_row   = ent_ok ? out_rd[OutW-1 -: RowW] : '0;
	assign out_value = ent_ok ? out_rd[ValueBits-1:0] : '0;

	`SMT_ASSERT(a_busy_stall, (state_q != S_IDLE) |-> in_stall, "input not stalled while busy")
	`SMT_ASSERT_NEXT(a_out_hold, (out_valid && out_stall), out_valid, "result dropped under stall")
	`SMT_ASSERT(a_count_max, (loaded_q <= CntW'(MaxNonzeros)), "entry count overflow")
	`SMT_ASSERT_NEXT(a_finish_done, (state_q == S_SCAT_RD && ei_q == loaded_q), finished_q,
		"finish did not set flag")
endmodule
